### rtl/hlc_pkg.sv
package hlc_pkg;

    localparam int CoordWidth  = 32;
    localparam int TFracBits   = 16;
    localparam int TWidth      = TFracBits + 1;
    localparam int NumPlanes   = 6;
    localparam int DistWidth   = CoordWidth + 2;
    // Magnitudes of plane distances and their sums
    localparam int MagWidth    = CoordWidth + 2;
    localparam int NumDivCells = TFracBits + 1;
    localparam int DiffWidth   = CoordWidth + 1;
    localparam int ProdWidth   = DiffWidth + TWidth;

    localparam logic [2:0] CODE_REJECT = 3'd0;
    localparam logic [2:0] CODE_WHOLE  = 3'd1;
    localparam logic [2:0] CODE_START  = 3'd2;
    localparam logic [2:0] CODE_END    = 3'd3;
    localparam logic [2:0] CODE_BOTH   = 3'd4;

    localparam logic [TWidth-1:0] T_ONE = TWidth'(1) << TFracBits;

    typedef struct packed {
        logic signed [CoordWidth-1:0] a_x;
        logic signed [CoordWidth-1:0] a_y;
        logic signed [CoordWidth-1:0] a_z;
        logic signed [CoordWidth-1:0] a_w;
        logic signed [CoordWidth-1:0] b_x;
        logic signed [CoordWidth-1:0] b_y;
        logic signed [CoordWidth-1:0] b_z;
        logic signed [CoordWidth-1:0] b_w;
    } t_in;

    typedef struct packed {
        logic [2:0]                   code;
        logic [TWidth-1:0]            t_start;
        logic [TWidth-1:0]            t_end;
        logic signed [CoordWidth-1:0] start_x;
        logic signed [CoordWidth-1:0] start_y;
        logic signed [CoordWidth-1:0] start_z;
        logic signed [CoordWidth-1:0] start_w;
        logic signed [CoordWidth-1:0] end_x;
        logic signed [CoordWidth-1:0] end_y;
        logic signed [CoordWidth-1:0] end_z;
        logic signed [CoordWidth-1:0] end_w;
    } t_out;

    typedef logic signed [CoordWidth-1:0] t_vec [4];

    // One plane's division in flight
    typedef struct packed {
        logic                  act;    // plane swept
        logic                  entry;  // A outside: entry t
        logic [MagWidth-1:0]   rem;
        logic [MagWidth-1:0]   den;
        logic [TWidth-1:0]     q;
    } t_div;

    typedef t_div t_divs [NumPlanes];

    // Item state carried along the divider cells
    typedef struct packed {
        logic   vld;
        logic   rej;
        t_in    pt;
    } t_ctl;

    function automatic logic signed [DistWidth-1:0] plane_dist(
        input logic signed [CoordWidth-1:0] x,
        input logic signed [CoordWidth-1:0] y,
        input logic signed [CoordWidth-1:0] z,
        input logic signed [CoordWidth-1:0] w,
        input int unsigned                  plane);
        logic signed [DistWidth-1:0] ex, ey, ez, ew, d;
        begin
            ex = DistWidth'(x);
            ey = DistWidth'(y);
            ez = DistWidth'(z);
            ew = DistWidth'(w);
            case (plane)
                0: d = ex + ew;
                1: d = ew - ex;
                2: d = ey + ew;
                3: d = ew - ey;
                4: d = ez;
                default: d = ew - ez;
            endcase
            return d;
        end
    endfunction

endpackage

### rtl/hlc_setup.sv
module hlc_setup (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_vld,
    input  hlc_pkg::t_in         i_pt,
    output hlc_pkg::t_ctl        o_ctl,
    output hlc_pkg::t_divs       o_div
);

    hlc_pkg::t_ctl  r_ctl;
    hlc_pkg::t_divs r_div;
    hlc_pkg::t_divs n_div;
    logic [hlc_pkg::NumPlanes-1:0] ca, cb;

    always_comb begin
        logic signed [hlc_pkg::DistWidth-1:0] da, db;
        logic [hlc_pkg::MagWidth-1:0] ma, mb;
        for (int p = 0; p < hlc_pkg::NumPlanes; p++) begin
            da = hlc_pkg::plane_dist(i_pt.a_x, i_pt.a_y, i_pt.a_z, i_pt.a_w, p);
            db = hlc_pkg::plane_dist(i_pt.b_x, i_pt.b_y, i_pt.b_z, i_pt.b_w, p);
            ca[p] = (da <= 0);
            cb[p] = (db <= 0);
            ma = da[hlc_pkg::DistWidth-1] ? hlc_pkg::MagWidth'(-da)
                                          : hlc_pkg::MagWidth'(da);
            mb = db[hlc_pkg::DistWidth-1] ? hlc_pkg::MagWidth'(-db)
                                          : hlc_pkg::MagWidth'(db);
            n_div[p].act   = ca[p] | cb[p];
            n_div[p].entry = ca[p];
            n_div[p].rem   = ma;
            // distances of opposite sense: |dA - dB| = |dA| + |dB|
            n_div[p].den   = ma + mb;
            n_div[p].q     = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl.vld <= 1'b0;
        end else begin
            r_ctl.vld <= i_vld;
        end
        r_ctl.rej <= |(ca & cb);
        r_ctl.pt  <= i_pt;
        r_div     <= n_div;
    end

    assign o_ctl = r_ctl;
    assign o_div = r_div;

endmodule

### rtl/hlc_div_cell.sv
module hlc_div_cell (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_first,
    input  hlc_pkg::t_ctl        i_ctl,
    input  hlc_pkg::t_divs       i_div,
    output hlc_pkg::t_ctl        o_ctl,
    output hlc_pkg::t_divs       o_div
);

    hlc_pkg::t_ctl  r_ctl;
    hlc_pkg::t_divs r_div;
    hlc_pkg::t_divs n_div;

    // One restoring quotient bit for every plane
    always_comb begin
        logic [hlc_pkg::MagWidth:0] r;
        for (int p = 0; p < hlc_pkg::NumPlanes; p++) begin
            n_div[p] = i_div[p];
            r = i_first ? {1'b0, i_div[p].rem} : {i_div[p].rem, 1'b0};
            n_div[p].q = {i_div[p].q[hlc_pkg::TWidth-2:0], 1'b0};
            if (r >= {1'b0, i_div[p].den}) begin
                r = r - {1'b0, i_div[p].den};
                n_div[p].q[0] = 1'b1;
            end
            n_div[p].rem = r[hlc_pkg::MagWidth-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl.vld <= 1'b0;
        end else begin
            r_ctl.vld <= i_ctl.vld;
        end
        r_ctl.rej <= i_ctl.rej;
        r_ctl.pt  <= i_ctl.pt;
        r_div     <= n_div;
    end

    assign o_ctl = r_ctl;
    assign o_div = r_div;

endmodule

### rtl/hlc_finish.sv
module hlc_finish (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  hlc_pkg::t_ctl        i_ctl,
    input  hlc_pkg::t_divs       i_div,
    output logic                 o_vld,
    output hlc_pkg::t_out        o_res
);

    localparam int CW = hlc_pkg::CoordWidth;
    localparam int DW = hlc_pkg::DiffWidth;
    localparam int PW = hlc_pkg::ProdWidth;
    localparam int TW = hlc_pkg::TWidth;
    localparam int F  = hlc_pkg::TFracBits;

    // stage 1: min/max reduction
    logic                  r1_vld, r1_rej, r1_ma, r1_mb;
    logic [TW-1:0]         r1_ts, r1_te;
    hlc_pkg::t_in          r1_pt;
    // stage 2: products (B-A)*t
    logic                  r2_vld, r2_rej, r2_ma, r2_mb;
    logic [TW-1:0]         r2_ts, r2_te;
    hlc_pkg::t_in          r2_pt;
    logic signed [PW-1:0]  r2_ps [4];
    logic signed [PW-1:0]  r2_pe [4];
    // output
    logic                  r_vld;
    hlc_pkg::t_out         r_res;

    logic [TW-1:0] n_ts, n_te;
    logic          n_ma, n_mb;
    always_comb begin
        n_ts = '0;
        n_te = hlc_pkg::T_ONE;
        n_ma = 1'b0;
        n_mb = 1'b0;
        for (int p = 0; p < hlc_pkg::NumPlanes; p++) begin
            if (i_div[p].act) begin
                if (i_div[p].entry) begin
                    if (i_div[p].q > n_ts) begin
                        n_ts = i_div[p].q;
                        n_ma = 1'b1;
                    end
                end else if (i_div[p].q < n_te) begin
                    n_te = i_div[p].q;
                    n_mb = 1'b1;
                end
            end
        end
    end

    hlc_pkg::t_vec a1, b1;
    always_comb begin
        a1[0] = r1_pt.a_x; a1[1] = r1_pt.a_y; a1[2] = r1_pt.a_z; a1[3] = r1_pt.a_w;
        b1[0] = r1_pt.b_x; b1[1] = r1_pt.b_y; b1[2] = r1_pt.b_z; b1[3] = r1_pt.b_w;
    end

    logic signed [PW-1:0] n_ps [4];
    logic signed [PW-1:0] n_pe [4];
    always_comb begin
        logic signed [DW-1:0] d;
        for (int i = 0; i < 4; i++) begin
            d = DW'(b1[i]) - DW'(a1[i]);
            n_ps[i] = PW'(d) * $signed({1'b0, r1_ts});
            n_pe[i] = PW'(d) * $signed({1'b0, r1_te});
        end
    end

    hlc_pkg::t_vec a2, sv, ev;
    always_comb begin
        a2[0] = r2_pt.a_x; a2[1] = r2_pt.a_y; a2[2] = r2_pt.a_z; a2[3] = r2_pt.a_w;
        ev[0] = r2_pt.b_x; ev[1] = r2_pt.b_y; ev[2] = r2_pt.b_z; ev[3] = r2_pt.b_w;
        sv = a2;
        for (int i = 0; i < 4; i++) begin
            // arithmetic shift gives floor division
            if (r2_ma) sv[i] = a2[i] + CW'(r2_ps[i] >>> F);
            if (r2_mb) ev[i] = a2[i] + CW'(r2_pe[i] >>> F);
        end
    end

    hlc_pkg::t_out n_res;
    always_comb begin
        n_res = '0;
        if (!r2_rej && (r2_ts <= r2_te)) begin
            if (r2_ma && r2_mb)  n_res.code = hlc_pkg::CODE_BOTH;
            else if (r2_ma)      n_res.code = hlc_pkg::CODE_START;
            else if (r2_mb)      n_res.code = hlc_pkg::CODE_END;
            else                 n_res.code = hlc_pkg::CODE_WHOLE;
            n_res.t_start = r2_ts;
            n_res.t_end   = r2_te;
            n_res.start_x = sv[0]; n_res.start_y = sv[1];
            n_res.start_z = sv[2]; n_res.start_w = sv[3];
            n_res.end_x   = ev[0]; n_res.end_y   = ev[1];
            n_res.end_z   = ev[2]; n_res.end_w   = ev[3];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r_vld  <= 1'b0;
        end else begin
            r1_vld <= i_ctl.vld;
            r2_vld <= r1_vld;
            r_vld  <= r2_vld;
        end
        r1_rej <= i_ctl.rej;
        r1_pt  <= i_ctl.pt;
        r1_ts  <= n_ts;
        r1_te  <= n_te;
        r1_ma  <= n_ma;
        r1_mb  <= n_mb;
        r2_rej <= r1_rej;
        r2_pt  <= r1_pt;
        r2_ts  <= r1_ts;
        r2_te  <= r1_te;
        r2_ma  <= r1_ma;
        r2_mb  <= r1_mb;
        r2_ps  <= n_ps;
        r2_pe  <= n_pe;
        r_res  <= n_res;
    end

    assign o_vld = r_vld;
    assign o_res = r_res;

endmodule

### rtl/homogeneous_line_clipper_top.sv
// Throughput: one line per clock; busy is never raised.
// Setup cell, one divider cell per quotient bit, then min/max, multiply, output.
// Reset (synchronous, active low) clears the valid bits of every stage.
// The receiver cannot stall: each result is on o_res for exactly one cycle.
module homogeneous_line_clipper_top (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  hlc_pkg::t_in     i_pt,
    output logic             o_done,
    output hlc_pkg::t_out    o_res
);

    localparam int N = hlc_pkg::NumDivCells;

    hlc_pkg::t_ctl  ctl [N+1];
    hlc_pkg::t_divs dv  [N+1];

    assign busy = 1'b0;

    hlc_setup u_setup (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (start),
        .i_pt    (i_pt),
        .o_ctl   (ctl[0]),
        .o_div   (dv[0])
    );

    for (genvar g = 0; g < N; g++) begin : g_cell
        hlc_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_first (g == 0),
            .i_ctl   (ctl[g]),
            .i_div   (dv[g]),
            .o_ctl   (ctl[g+1]),
            .o_div   (dv[g+1])
        );
    end

    hlc_finish u_finish (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl[N]),
        .i_div   (dv[N]),
        .o_vld   (o_done),
        .o_res   (o_res)
    );

endmodule

### rtl/hlc_checker.sv
module hlc_checker (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    input  logic             busy,
    input  logic             o_done,
    input  hlc_pkg::t_out    o_res
);

    localparam int Lat = hlc_pkg::NumDivCells + 4;

    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start && !busy, Lat))
        else $error("result without transaction");

    a_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_res.code <= hlc_pkg::CODE_BOTH))
        else $error("bad code");

    a_rej: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_res.code == hlc_pkg::CODE_REJECT) |->
            (o_res.t_end == '0 && o_res.start_x == '0))
        else $error("reject not cleared");

    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_res.code != hlc_pkg::CODE_REJECT) |->
            (o_res.t_start <= o_res.t_end && o_res.t_end <= hlc_pkg::T_ONE))
        else $error("t order");

endmodule

bind homogeneous_line_clipper_top hlc_checker u_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_done  (o_done),
    .o_res   (o_res)
);
